FILE: rtl/core/two_channel_sync_demod_uart_reporter_core_macros.svh
// Assertion helpers shared by the checker files.
// Each macro samples on clk and is quiet while rst_n is low.
`ifndef TWO_CHANNEL_SYNC_DEMOD_UART_REPORTER_CORE_MACROS_SVH
`define TWO_CHANNEL_SYNC_DEMOD_UART_REPORTER_CORE_MACROS_SVH

// Same-cycle implication.
`define TCSD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCSD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/tcsd_pkg.sv
`default_nettype none

package tcsd_pkg;

    localparam int SAMPLES_PER_ROUND = 256;
    localparam int CNT_W             = $clog2(SAMPLES_PER_ROUND + 2);
    localparam int LINE_CHARS        = 9;
    localparam int CI_W              = 4;

    localparam int ADC_W       = 10;
    localparam int DIFF_W      = ADC_W + 2;
    localparam int ACC_W       = 16;
    localparam int SHIFT_W     = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 8;
    localparam int PROD_W      = 32;
    localparam int RECIP_SHIFT = 19;

    // x / 10 == (x * RECIP_10) >> RECIP_SHIFT for every 16-bit x
    localparam logic [ACC_W-1:0] RECIP_10 = 16'hCCCD;

    localparam logic [CI_W-1:0] DIGIT_FIRST_POS = 4'd7;

    localparam logic [1:0] PH_SAMPLE_A = 2'd0;
    localparam logic [1:0] PH_SAMPLE_B = 2'd1;
    localparam logic [1:0] PH_SEND_A   = 2'd2;
    localparam logic [1:0] PH_SEND_B   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_A  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_B  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG_SHIFT = 2'd2;

    localparam logic [SHIFT_W-1:0] AVG_SHIFT_RESET = 4'd7;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef struct packed {
        logic capture;
        logic exec;
        logic lp_load;
        logic digit;
        logic out_load;
    } tcsd_cmd_t;

    typedef struct packed {
        logic line_start;
        logic v_zero;
        logic out_free;
    } tcsd_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/two_channel_sync_demod_uart_reporter_core.sv
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid / s_axis_tready tuser: action, tdata: adc_sample
// m_axis    out        m_axis_tvalid / m_axis_tready tdata: line, drives, start, phase, done
// cfg       in         cfg_we (no back-pressure)     cfg_index, cfg_data
//
// An ordinary request goes through accept, execute the step, load the result register.
// A request that opens a report line adds steps: forming the low-pass value and its shift,
// then the decimal digits, one at a time, from a reciprocal multiply, and a step to see the
// value exhausted.
// Reset (rst_n, asynchronous) puts the block in channel A sampling with count 1, tx high.
// A stalled result holds in the output register; the next request is accepted meanwhile
// and waits in its final step until the register frees.
`default_nettype none

module two_channel_sync_demod_uart_reporter_core (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    // [9:0] adc_sample, [15:10] zero
    input  wire [tcsd_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // [0] action
    input  wire                                s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    // [0] tx_line, [1] drive_a, [2] drive_b, [3] start_conversion, [5:4] phase,
    // [6] char_done, [7] zero
    output logic [tcsd_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  wire                                cfg_we,
    input  wire [tcsd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire [tcsd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    tcsd_pkg::tcsd_cmd_t  cmd;
    tcsd_pkg::tcsd_stat_t stat;

    // sequencer: accept, execute, optional line formatting, result hand-off
    tcsd_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // demodulator, line buffer, UART shifter and result register
    tcsd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_action (s_axis_tuser),
        .in_sample (s_axis_tdata[tcsd_pkg::ADC_W-1:0]),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire

FILE: rtl/core/tcsd_ctrl.sv
`default_nettype none

module tcsd_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 s_valid,
    output logic                s_ready,
    input  tcsd_pkg::tcsd_stat_t stat,
    output tcsd_pkg::tcsd_cmd_t  cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_LP    = 5'b00100,
        S_DIGIT = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        s_ready      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = stat.line_start ? S_LP : S_OUT;
            end
            S_LP:
            begin
                cmd.lp_load = 1'b1;
                state_next  = S_DIGIT;
            end
            S_DIGIT:
            begin
                cmd.digit = 1'b1;
                if (stat.v_zero)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                cmd.out_load = stat.out_free;
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/tcsd_datapath.sv
`default_nettype none

module tcsd_datapath (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  tcsd_pkg::tcsd_cmd_t                     cmd,
    output tcsd_pkg::tcsd_stat_t                    stat,
    input  wire                                    in_action,
    input  wire [tcsd_pkg::ADC_W-1:0]              in_sample,
    input  wire                                    cfg_we,
    input  wire [tcsd_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  wire [tcsd_pkg::CFG_DATA_W-1:0]         cfg_data,
    output logic                                   out_valid,
    input  wire                                    out_ready,
    output logic [tcsd_pkg::M_TDATA_W-1:0]         out_data
);

    // item latched at accept
    logic                        action_reg;
    logic [tcsd_pkg::ADC_W-1:0]  sample_in_reg;

    // configuration
    logic [tcsd_pkg::ADC_W-1:0]   offset_a_reg;
    logic [tcsd_pkg::ADC_W-1:0]   offset_b_reg;
    logic [tcsd_pkg::SHIFT_W-1:0] avg_shift_reg;

    // block state
    logic [1:0]                  phase_reg,   phase_next;
    logic [tcsd_pkg::CNT_W-1:0]  cnt_reg,     cnt_next;
    logic [tcsd_pkg::ADC_W-1:0]  prev_reg,    prev_next;
    logic [tcsd_pkg::ADC_W-1:0]  cur_reg,     cur_next;
    logic [tcsd_pkg::ACC_W-1:0]  acc_reg  [2];
    logic [tcsd_pkg::ACC_W-1:0]  acc_next [2];
    logic [tcsd_pkg::ACC_W-1:0]  lp_reg   [2];
    logic [tcsd_pkg::ACC_W-1:0]  lp_next  [2];
    logic [7:0]                  line_reg  [tcsd_pkg::LINE_CHARS];
    logic [7:0]                  line_next [tcsd_pkg::LINE_CHARS];
    logic [tcsd_pkg::CI_W-1:0]   ci_reg,      ci_next;
    logic [3:0]                  bc_reg,      bc_next;
    logic [7:0]                  txsh_reg,    txsh_next;
    logic                        drive_reg,   drive_next;
    logic                        tx_reg,      tx_next;
    logic                        start_reg,   start_next;
    logic                        done_reg,    done_next;
    logic                        line_ch_reg, line_ch_next;
    logic [tcsd_pkg::ACC_W-1:0]  v_reg,       v_next;
    logic [tcsd_pkg::CI_W-1:0]   pos_reg,     pos_next;

    // output register
    logic                           m_valid_reg, m_valid_next;
    logic [tcsd_pkg::M_TDATA_W-1:0] m_data_reg,  m_data_next;

    logic                        ch;
    logic [tcsd_pkg::ADC_W-1:0]  offset_sel;
    logic [tcsd_pkg::DIFF_W-1:0] diff;
    logic                        round_end;
    logic                        line_end;
    logic                        open_line;
    logic                        open_ch;
    logic [tcsd_pkg::PROD_W-1:0] prod;
    logic [tcsd_pkg::ACC_W-1:0]  quot;
    logic [tcsd_pkg::ACC_W-1:0]  rem;

    assign ch         = phase_reg[0];
    assign offset_sel = ch ? offset_b_reg : offset_a_reg;
    assign diff       = {2'b00, cur_reg} - {2'b00, sample_in_reg} - {2'b00, offset_sel};
    assign round_end  = (cnt_reg > tcsd_pkg::CNT_W'(tcsd_pkg::SAMPLES_PER_ROUND));
    assign line_end   = (ci_reg >= tcsd_pkg::CI_W'(tcsd_pkg::LINE_CHARS));

    // a line opens when channel B's round ends or when line A has been sent
    assign open_line  = (!action_reg && phase_reg == tcsd_pkg::PH_SAMPLE_B && round_end)
                     || (action_reg && phase_reg == tcsd_pkg::PH_SEND_A && line_end);
    assign open_ch    = action_reg;

    assign prod = tcsd_pkg::PROD_W'(v_reg) * tcsd_pkg::PROD_W'(tcsd_pkg::RECIP_10);
    assign quot = tcsd_pkg::ACC_W'(prod[tcsd_pkg::PROD_W-1:tcsd_pkg::RECIP_SHIFT]);
    assign rem  = v_reg - ({quot[tcsd_pkg::ACC_W-4:0], 3'b000} + {quot[tcsd_pkg::ACC_W-2:0], 1'b0});

    assign stat.line_start = open_line;
    assign stat.v_zero     = (v_reg == '0);
    assign stat.out_free   = !m_valid_reg || out_ready;

    assign out_valid = m_valid_reg;
    assign out_data  = m_data_reg;

    always_comb
    begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        prev_next    = prev_reg;
        cur_next     = cur_reg;
        acc_next     = acc_reg;
        lp_next      = lp_reg;
        line_next    = line_reg;
        ci_next      = ci_reg;
        bc_next      = bc_reg;
        txsh_next    = txsh_reg;
        drive_next   = drive_reg;
        tx_next      = tx_reg;
        start_next   = start_reg;
        done_next    = done_reg;
        line_ch_next = line_ch_reg;
        v_next       = v_reg;
        pos_next     = pos_reg;

        if (cmd.exec)
        begin
            start_next = 1'b0;
            done_next  = 1'b0;
            if (!action_reg)
            begin
                if (!phase_reg[1])
                begin
                    prev_next = cur_reg;
                    cur_next  = sample_in_reg;
                    if (!round_end)
                    begin
                        // accumulate on even counts, drop negative differences
                        if (!cnt_reg[0] && !diff[tcsd_pkg::DIFF_W-1])
                        begin
                            acc_next[ch] = acc_reg[ch]
                                         + tcsd_pkg::ACC_W'(diff[tcsd_pkg::ADC_W-1:0]);
                        end
                        cnt_next   = cnt_reg + 1'b1;
                        drive_next = ~drive_reg;
                        start_next = 1'b1;
                    end
                    else if (!ch)
                    begin
                        phase_next  = tcsd_pkg::PH_SAMPLE_B;
                        acc_next[1] = '0;
                        cnt_next    = tcsd_pkg::CNT_W'(1);
                        prev_next   = '0;
                        cur_next    = '0;
                        drive_next  = 1'b0;
                        tx_next     = 1'b1;
                        start_next  = 1'b1;
                    end
                end
            end
            else if (phase_reg[1])
            begin
                if (!line_end)
                begin
                    if (bc_reg == 4'd0)
                    begin
                        tx_next   = 1'b0;
                        txsh_next = line_reg[ci_reg];
                        bc_next   = 4'd1;
                    end
                    else if (bc_reg >= 4'd9)
                    begin
                        tx_next   = 1'b1;
                        bc_next   = 4'd0;
                        ci_next   = ci_reg + 1'b1;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        tx_next   = txsh_reg[0];
                        txsh_next = {1'b0, txsh_reg[7:1]};
                        bc_next   = bc_reg + 1'b1;
                    end
                end
                else if (phase_reg == tcsd_pkg::PH_SEND_B)
                begin
                    phase_next  = tcsd_pkg::PH_SAMPLE_A;
                    acc_next[0] = '0;
                    cnt_next    = tcsd_pkg::CNT_W'(1);
                    prev_next   = '0;
                    cur_next    = '0;
                    drive_next  = 1'b0;
                    tx_next     = 1'b1;
                    start_next  = 1'b1;
                end
            end

            if (open_line)
            begin
                lp_next[open_ch] = {1'b0, lp_reg[open_ch][tcsd_pkg::ACC_W-1:1]}
                                 + {1'b0, acc_reg[open_ch][tcsd_pkg::ACC_W-1:1]};
                for (int i = 0; i < tcsd_pkg::LINE_CHARS; i++)
                begin
                    line_next[i] = tcsd_pkg::CH_SPACE;
                end
                line_next[0] = open_ch ? tcsd_pkg::CH_B : tcsd_pkg::CH_A;
                line_next[tcsd_pkg::LINE_CHARS-1] = open_ch ? tcsd_pkg::CH_NL
                                                            : tcsd_pkg::CH_COMMA;
                line_ch_next = open_ch;
                phase_next   = {1'b1, open_ch};
                ci_next      = '0;
                tx_next      = 1'b1;
            end
        end

        if (cmd.lp_load)
        begin
            v_next   = lp_reg[line_ch_reg] >> avg_shift_reg;
            pos_next = tcsd_pkg::DIGIT_FIRST_POS;
        end

        if (cmd.digit)
        begin
            if (v_reg == '0)
            begin
                if (pos_reg == tcsd_pkg::DIGIT_FIRST_POS)
                begin
                    line_next[tcsd_pkg::DIGIT_FIRST_POS] = tcsd_pkg::CH_ZERO;
                end
            end
            else
            begin
                line_next[pos_reg] = tcsd_pkg::CH_ZERO + {4'b0000, rem[3:0]};
                v_next             = quot;
                pos_next           = pos_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (cmd.out_load)
        begin
            m_valid_next = 1'b1;
            m_data_next  = {1'b0, done_reg, phase_reg, start_reg,
                            (phase_reg == tcsd_pkg::PH_SAMPLE_B) && drive_reg,
                            (phase_reg == tcsd_pkg::PH_SAMPLE_A) && drive_reg,
                            tx_reg};
        end
        else if (out_ready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg    <= in_action;
            sample_in_reg <= in_sample;
        end
        line_reg   <= line_next;
        m_data_reg <= m_data_next;
        v_reg      <= v_next;
        pos_reg    <= pos_next;
        txsh_reg   <= txsh_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_a_reg  <= '0;
            offset_b_reg  <= '0;
            avg_shift_reg <= tcsd_pkg::AVG_SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tcsd_pkg::CFG_OFFSET_A:  offset_a_reg  <= cfg_data;
                tcsd_pkg::CFG_OFFSET_B:  offset_b_reg  <= cfg_data;
                tcsd_pkg::CFG_AVG_SHIFT: avg_shift_reg <= cfg_data[tcsd_pkg::SHIFT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= tcsd_pkg::PH_SAMPLE_A;
            cnt_reg     <= tcsd_pkg::CNT_W'(1);
            prev_reg    <= '0;
            cur_reg     <= '0;
            acc_reg[0]  <= '0;
            acc_reg[1]  <= '0;
            lp_reg[0]   <= '0;
            lp_reg[1]   <= '0;
            ci_reg      <= '0;
            bc_reg      <= '0;
            drive_reg   <= 1'b0;
            tx_reg      <= 1'b1;
            start_reg   <= 1'b0;
            done_reg    <= 1'b0;
            line_ch_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            prev_reg    <= prev_next;
            cur_reg     <= cur_next;
            acc_reg     <= acc_next;
            lp_reg      <= lp_next;
            ci_reg      <= ci_next;
            bc_reg      <= bc_next;
            drive_reg   <= drive_next;
            tx_reg      <= tx_next;
            start_reg   <= start_next;
            done_reg    <= done_next;
            line_ch_reg <= line_ch_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tcsd_checker.sv
`default_nettype none

`include "two_channel_sync_demod_uart_reporter_core_macros.svh"

module tcsd_checker (
    input wire                            clk,
    input wire                            rst_n,
    input wire                            s_axis_tvalid,
    input wire                            s_axis_tready,
    input wire                            m_axis_tvalid,
    input wire                            m_axis_tready,
    input wire [tcsd_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

    // a stalled result stays offered
    `TCSD_ASSERT_NXT(a_hold_valid, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")

    // one request at a time: no accept right after an accept
    `TCSD_ASSERT_NXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready, "back-to-back accept")

    // while sending, drives are low and no conversion is requested
    `TCSD_ASSERT_IMP(a_send_quiet, m_axis_tvalid && m_axis_tdata[5], !m_axis_tdata[1] && !m_axis_tdata[2] && !m_axis_tdata[3], "activity while sending")

    // the stop-bit tick leaves the line high and only occurs while sending
    `TCSD_ASSERT_IMP(a_stop_high, m_axis_tvalid && m_axis_tdata[6], m_axis_tdata[0] && m_axis_tdata[5], "bad stop bit")

endmodule

bind two_channel_sync_demod_uart_reporter_core tcsd_checker u_tcsd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
